FILE: rtl/page_lcd_rect_raster_op_defines.svh
// Assertion macros shared by the checker files of the page display block.
// Each macro samples on the rising edge of clock.
`ifndef PAGE_LCD_RECT_RASTER_OP_DEFINES_SVH
`define PAGE_LCD_RECT_RASTER_OP_DEFINES_SVH

// Consequence must hold in the cycle after the antecedent, ignored during reset.
`define PLRO_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("page display block check failed");

// Consequence must hold in the same cycle as the antecedent, ignored during reset.
`define PLRO_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("page display block check failed");

// Next-cycle implication that stays active while reset is high.
`define PLRO_ASSERT_ALWAYS_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("page display block check failed");

`endif

FILE: rtl/plro_pkg.sv
package plro_pkg;

   // Field widths fixed by the request format and the parameter ranges.
   localparam int PAGE_W = 5;   // up to 32 pages
   localparam int COL_W  = 8;   // up to 256 columns
   localparam int ROW_W  = 3;   // eight rows in a page
   localparam int GEO_W  = 11;  // signed band geometry, covers -1024..1023

   typedef enum logic [1:0] {
      OP_READ    = 2'd0,
      OP_FILL    = 2'd1,
      OP_RECT    = 2'd2,
      OP_OUTLINE = 2'd3
   } plro_op_type;

   typedef enum logic [1:0] {
      MODE_PUT   = 2'd0,
      MODE_XOR   = 2'd1,
      MODE_ERASE = 2'd2,
      MODE_KEEP  = 2'd3
   } plro_mode_type;

   // One clipped band, handed from the sequencer to the word walker.
   typedef struct packed {
      logic [PAGE_W-1:0] page_first;
      logic [PAGE_W-1:0] page_last;
      logic [COL_W-1:0]  col_first;
      logic [COL_W-1:0]  col_last;
      logic [ROW_W-1:0]  row_first;
      logic [ROW_W-1:0]  row_last;
      logic [1:0]        color;
      plro_mode_type     mode;
   } plro_band_type;

   // Combine a row pattern into a stored word.
   function automatic logic [15:0] combine(input logic [15:0] word,
                                           input logic [15:0] pat,
                                           input plro_mode_type mode);
      logic [15:0] result;
      case (mode)
         MODE_PUT:   result = word | pat;
         MODE_XOR:   result = word ^ pat;
         MODE_ERASE: result = word & ~pat;
         default:    result = word;
      endcase
      return result;
   endfunction

endpackage

FILE: rtl/plro_ram.sv
module plro_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2560
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/plro_walker.sv
module plro_walker #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 20
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  plro_pkg::plro_band_type              cmd,
   output logic                                 busy,
   output logic                                 rd_en,
   output logic [$clog2(COLUMNS*PAGES)-1:0]     rd_addr,
   input  logic [15:0]                          rd_data,
   output logic                                 wr_en,
   output logic [$clog2(COLUMNS*PAGES)-1:0]     wr_addr,
   output logic [15:0]                          wr_data
);

   localparam int AW = $clog2(COLUMNS * PAGES);

   logic                            run_ff, run_in;
   plro_pkg::plro_band_type         cmd_ff, cmd_in;
   logic [plro_pkg::PAGE_W-1:0]     page_ff, page_in;
   logic [plro_pkg::COL_W-1:0]      col_ff, col_in;
   logic                            wr_pend_ff;
   logic [AW-1:0]                   wr_addr_ff;
   logic [15:0]                     pat_ff;

   logic [plro_pkg::ROW_W-1:0]      row_lo, row_hi;
   logic [7:0]                      mask;
   logic [15:0]                     pat;
   logic [AW-1:0]                   addr_cur;

   // Rows covered in the current page: only the first and last pages are partial.
   always_comb begin
      row_lo = (page_ff == cmd_ff.page_first) ? cmd_ff.row_first : '0;
      row_hi = (page_ff == cmd_ff.page_last) ? cmd_ff.row_last : '1;
      mask   = (8'hFF << row_lo) & (8'hFF >> (3'd7 - row_hi));
      pat    = {(cmd_ff.color[1] ? mask : 8'h00), (cmd_ff.color[0] ? mask : 8'h00)};
   end

   assign addr_cur = AW'(int'(page_ff) * COLUMNS + int'(col_ff));

   // Column-major sweep within a page, one word read per cycle.
   always_comb begin
      run_in  = run_ff;
      cmd_in  = cmd_ff;
      page_in = page_ff;
      col_in  = col_ff;
      if (start) begin
         run_in  = 1'b1;
         cmd_in  = cmd;
         page_in = cmd.page_first;
         col_in  = cmd.col_first;
      end else if (run_ff) begin
         if (col_ff == cmd_ff.col_last) begin
            col_in = cmd_ff.col_first;
            if (page_ff == cmd_ff.page_last) begin
               run_in = 1'b0;
            end else begin
               page_in = page_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff     <= 1'b0;
         wr_pend_ff <= 1'b0;
      end else begin
         run_ff     <= run_in;
         wr_pend_ff <= run_ff;
      end
      cmd_ff     <= cmd_in;
      page_ff    <= page_in;
      col_ff     <= col_in;
      wr_addr_ff <= addr_cur;
      pat_ff     <= pat;
   end

   // The word read last cycle is written back while the next one is read.
   assign busy    = run_ff || wr_pend_ff;
   assign rd_en   = run_ff;
   assign rd_addr = addr_cur;
   assign wr_en   = wr_pend_ff;
   assign wr_addr = wr_addr_ff;
   assign wr_data = plro_pkg::combine(rd_data, pat_ff, cmd_ff.mode);

endmodule

FILE: rtl/page_lcd_rect_raster_op.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  op, x, y, width, height, line_width,
//                                             color, mode, fill_byte, page
// rsp_      out        rsp_valid / rsp_stall  upper_plane, lower_plane
//
// A read request naming a word outside the memory returns zero without a memory read.
// A fill writes all COLUMNS*PAGES words in turn: the single memory write port is the limit.
// A filled rectangle visits each covered word once and skips the walk when it draws nothing;
// an outline runs four such bands in turn, so a word in two bands is visited twice.
// After reset a clearing pass writes zero to all COLUMNS*PAGES words, one per cycle,
// and req_stall stays high until it ends. Reset is synchronous and active high.
// One request is in work at a time; the next is accepted while a response still
// waits on rsp_stall, and it finishes only once the response register is free.
module page_lcd_rect_raster_op #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 20
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_op,
   input  logic [6:0] req_x,
   input  logic [7:0] req_y,
   input  logic [7:0] req_width,
   input  logic [7:0] req_height,
   input  logic [6:0] req_line_width,
   input  logic [1:0] req_color,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_fill_byte,
   input  logic [4:0] req_page,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_upper_plane,
   output logic [7:0] rsp_lower_plane
);

   localparam int DEPTH = COLUMNS * PAGES;
   localparam int AW    = $clog2(DEPTH);
   localparam int GW    = plro_pkg::GEO_W;
   localparam logic signed [GW-1:0] ROWS_S = GW'(8 * PAGES);
   localparam logic signed [GW-1:0] COLS_S = GW'(COLUMNS);
   localparam logic signed [GW-1:0] ONE_S  = GW'(1);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_READ_DATA,
      ST_FILL,
      ST_SETUP,
      ST_END,
      ST_CLIP,
      ST_WALK,
      ST_FINISH
   } state_type;

   state_type                state_ff, state_in;
   logic [AW-1:0]            sweep_addr_ff, sweep_addr_in;
   logic [1:0]               band_ff, band_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               rsp_upper_ff, rsp_upper_in;
   logic [7:0]               rsp_lower_ff, rsp_lower_in;
   logic [7:0]               res_upper_ff, res_upper_in;
   logic [7:0]               res_lower_ff, res_lower_in;

   // Request fields held for the length of the operation.
   plro_pkg::plro_op_type    op_ff;
   logic [6:0]               x_ff;
   logic [7:0]               y_ff;
   logic [7:0]               width_ff;
   logic [7:0]               height_ff;
   logic [6:0]               line_width_ff;
   logic [1:0]               color_ff;
   plro_pkg::plro_mode_type  mode_ff;
   logic [7:0]               fill_ff;
   logic [4:0]               page_ff;

   // Band geometry pipeline: origin and size, then far edges, then clipped bounds.
   logic signed [GW-1:0]     bx_ff, by_ff, bw_ff, bh_ff;
   logic signed [GW-1:0]     bx_in, by_in, bw_in, bh_in;
   logic signed [GW-1:0]     xe_ff, ye_ff;
   logic                     empty_ff;

   logic signed [GW-1:0]     x_s, y_s, w_s, h_s, lw_s, side_raw, side_s;
   logic signed [GW-1:0]     r0, r1, c0, c1, r1m, c1m;
   logic                     clip_skip;
   logic                     outline_void;
   logic                     last_band;
   plro_pkg::plro_band_type  band_cmd;

   logic                     accept;
   logic                     rsp_free;
   logic                     read_in_range;
   logic [AW-1:0]            read_addr;

   logic                     walk_start, walk_busy;
   logic                     walk_rd_en, walk_wr_en;
   logic [AW-1:0]            walk_rd_addr, walk_wr_addr;
   logic [15:0]              walk_wr_data;

   logic                     ram_wr_en, ram_rd_en;
   logic [AW-1:0]            ram_wr_addr, ram_rd_addr;
   logic [15:0]              ram_wr_data, ram_rd_data;
   logic                     sweep_wr_en;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Signed views of the held request for the band arithmetic.
   assign x_s      = GW'(x_ff);
   assign y_s      = GW'(y_ff);
   assign w_s      = GW'(width_ff);
   assign h_s      = GW'(height_ff);
   assign lw_s     = GW'(line_width_ff);
   assign side_raw = h_s - (lw_s <<< 1);
   assign side_s   = side_raw[GW-1] ? '0 : side_raw;

   // An outline with any zero size draws nothing at all.
   assign outline_void = (op_ff == plro_pkg::OP_OUTLINE) &&
                         (width_ff == '0 || height_ff == '0 || line_width_ff == '0);
   assign last_band    = (op_ff != plro_pkg::OP_OUTLINE) || (band_ff == 2'd3);

   // Outline bands in order: top, bottom, left side, right side.
   always_comb begin
      bx_in = x_s;
      by_in = y_s;
      bw_in = w_s;
      bh_in = h_s;
      if (op_ff == plro_pkg::OP_OUTLINE) begin
         case (band_ff)
            2'd0: begin
               bh_in = lw_s;
            end
            2'd1: begin
               by_in = y_s + h_s - lw_s;
               bh_in = lw_s;
            end
            2'd2: begin
               by_in = y_s + lw_s;
               bw_in = lw_s;
               bh_in = side_s;
            end
            default: begin
               bx_in = x_s + w_s - lw_s;
               by_in = y_s + lw_s;
               bw_in = lw_s;
               bh_in = side_s;
            end
         endcase
      end
   end

   // Clip the band to the memory and split it into page and row bounds.
   always_comb begin
      r0  = by_ff[GW-1] ? '0 : by_ff;
      r1  = (ye_ff > ROWS_S) ? ROWS_S : ye_ff;
      c0  = bx_ff[GW-1] ? '0 : bx_ff;
      c1  = (xe_ff > COLS_S) ? COLS_S : xe_ff;
      r1m = r1 - ONE_S;
      c1m = c1 - ONE_S;
      clip_skip = empty_ff || (r0 >= r1) || (c0 >= c1);
      band_cmd.page_first = r0[plro_pkg::ROW_W +: plro_pkg::PAGE_W];
      band_cmd.page_last  = r1m[plro_pkg::ROW_W +: plro_pkg::PAGE_W];
      band_cmd.row_first  = r0[plro_pkg::ROW_W-1:0];
      band_cmd.row_last   = r1m[plro_pkg::ROW_W-1:0];
      band_cmd.col_first  = c0[plro_pkg::COL_W-1:0];
      band_cmd.col_last   = c1m[plro_pkg::COL_W-1:0];
      band_cmd.color      = color_ff;
      band_cmd.mode       = mode_ff;
   end

   assign walk_start = (state_ff == ST_CLIP) && !clip_skip;

   // A read outside the memory returns zero without touching the memory.
   assign read_in_range = (int'(page_ff) < PAGES) && (int'(x_ff) < COLUMNS);
   assign read_addr     = AW'(int'(page_ff) * COLUMNS + int'(x_ff));

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      sweep_addr_in = sweep_addr_ff;
      band_in       = band_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_upper_in  = rsp_upper_ff;
      rsp_lower_in  = rsp_lower_ff;
      res_upper_in  = res_upper_ff;
      res_lower_in  = res_lower_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            sweep_addr_in = sweep_addr_ff + 1'b1;
            if (sweep_addr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               res_upper_in  = '0;
               res_lower_in  = '0;
               sweep_addr_in = '0;
               band_in       = '0;
               case (plro_pkg::plro_op_type'(req_op))
                  plro_pkg::OP_READ: state_in = ST_READ;
                  plro_pkg::OP_FILL: state_in = ST_FILL;
                  default:           state_in = ST_SETUP;
               endcase
            end
         end
         ST_READ: begin
            state_in = read_in_range ? ST_READ_DATA : ST_FINISH;
         end
         ST_READ_DATA: begin
            res_upper_in = ram_rd_data[15:8];
            res_lower_in = ram_rd_data[7:0];
            state_in     = ST_FINISH;
         end
         ST_FILL: begin
            sweep_addr_in = sweep_addr_ff + 1'b1;
            if (sweep_addr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_SETUP: begin
            state_in = outline_void ? ST_FINISH : ST_END;
         end
         ST_END: begin
            state_in = ST_CLIP;
         end
         ST_CLIP: begin
            if (!clip_skip) begin
               state_in = ST_WALK;
            end else if (last_band) begin
               state_in = ST_FINISH;
            end else begin
               band_in  = band_ff + 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_WALK: begin
            if (!walk_busy) begin
               if (last_band) begin
                  state_in = ST_FINISH;
               end else begin
                  band_in  = band_ff + 1'b1;
                  state_in = ST_SETUP;
               end
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_upper_in = res_upper_ff;
               rsp_lower_in = res_lower_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         sweep_addr_ff <= '0;
         band_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_addr_ff <= sweep_addr_in;
         band_ff       <= band_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_upper_ff <= rsp_upper_in;
      rsp_lower_ff <= rsp_lower_in;
      res_upper_ff <= res_upper_in;
      res_lower_ff <= res_lower_in;
      if (accept) begin
         op_ff         <= plro_pkg::plro_op_type'(req_op);
         x_ff          <= req_x;
         y_ff          <= req_y;
         width_ff      <= req_width;
         height_ff     <= req_height;
         line_width_ff <= req_line_width;
         color_ff      <= req_color;
         mode_ff       <= plro_pkg::plro_mode_type'(req_mode);
         fill_ff       <= req_fill_byte;
         page_ff       <= req_page;
      end
      if (state_ff == ST_SETUP) begin
         bx_ff <= bx_in;
         by_ff <= by_in;
         bw_ff <= bw_in;
         bh_ff <= bh_in;
      end
      if (state_ff == ST_END) begin
         xe_ff    <= bx_ff + bw_ff;
         ye_ff    <= by_ff + bh_ff;
         empty_ff <= bw_ff[GW-1] || (bw_ff == '0) || bh_ff[GW-1] || (bh_ff == '0) ||
                     (mode_ff == plro_pkg::MODE_KEEP);
      end
   end

   plro_walker #(
      .COLUMNS (COLUMNS),
      .PAGES   (PAGES)
   ) u_walker (
      .clock   (clock),
      .reset   (reset),
      .start   (walk_start),
      .cmd     (band_cmd),
      .busy    (walk_busy),
      .rd_en   (walk_rd_en),
      .rd_addr (walk_rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (walk_wr_en),
      .wr_addr (walk_wr_addr),
      .wr_data (walk_wr_data)
   );

   // The clearing pass and fill share the sweep counter; the walker owns the
   // memory while it draws a band.
   assign sweep_wr_en = (state_ff == ST_CLEAR) || (state_ff == ST_FILL);
   assign ram_wr_en   = walk_wr_en || sweep_wr_en;
   assign ram_wr_addr = walk_wr_en ? walk_wr_addr : sweep_addr_ff;
   assign ram_wr_data = walk_wr_en ? walk_wr_data :
                        ((state_ff == ST_FILL) ? {fill_ff, fill_ff} : 16'h0000);
   assign ram_rd_en   = walk_rd_en || ((state_ff == ST_READ) && read_in_range);
   assign ram_rd_addr = walk_rd_en ? walk_rd_addr : read_addr;

   plro_ram #(
      .WIDTH (16),
      .DEPTH (DEPTH)
   ) u_display_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_upper_plane = rsp_upper_ff;
   assign rsp_lower_plane = rsp_lower_ff;

endmodule

FILE: rtl/plro_checker.sv
`include "page_lcd_rect_raster_op_defines.svh"

module plro_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_upper_plane,
   input logic [7:0] rsp_lower_plane
);

   // The clearing pass starts after every reset cycle, so no request can enter.
   `PLRO_ASSERT_ALWAYS_NEXT(a_stall_after_reset, reset, req_stall)

   // Every request keeps the block busy for at least the following cycle.
   `PLRO_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

   // A response appears only out of a busy cycle of the sequencer.
   `PLRO_ASSERT_SAME(a_rsp_from_work, $rose(rsp_valid), $past(req_stall))

   // A stalled response holds its data.
   `PLRO_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
                     rsp_valid && $stable(rsp_upper_plane) && $stable(rsp_lower_plane))

endmodule

bind page_lcd_rect_raster_op plro_checker u_plro_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_upper_plane (rsp_upper_plane),
   .rsp_lower_plane (rsp_lower_plane)
);

FILE: tb/sv/tb_page_lcd_rect_raster_op.sv
`timescale 1ns / 100ps

// Geometry of the display memory under test; the block is built with the same values.
localparam int FRAME_COLUMNS = 128;
localparam int FRAME_PAGES   = 20;
localparam int FRAME_ROWS    = FRAME_PAGES * 8;

// One request as it sits on the req_ ports, in port order.
typedef struct packed {
   plro_pkg::plro_op_type   op;
   logic [6:0]              x;
   logic [7:0]              y;
   logic [7:0]              cols;
   logic [7:0]              rows;
   logic [6:0]              line;
   logic [1:0]              color;
   plro_pkg::plro_mode_type mode;
   logic [7:0]              fill;
   logic [4:0]              page;
} raster_request_type;

// Shadow copy of the display memory plus the words that reads are still owed.
class frame_scoreboard_type;
   logic [15:0] frame [];
   logic [15:0] planes_due [$];
   int          mismatches;
   int          responses;

   function new();
      frame = new[FRAME_PAGES*FRAME_COLUMNS];
      foreach (frame[i]) frame[i] = 16'h0000;
      mismatches = 0;
      responses  = 0;
   endfunction

   function int pending();
      return planes_due.size();
   endfunction

   task report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
   endtask

   // Combine one clipped band into the shadow frame, page by page.
   function void paint_band(int bx, int by, int bw, int bh, logic [1:0] color,
                            plro_pkg::plro_mode_type mode);
      int          r0, r1, c0, c1, lo, hi, pg, col, idx;
      logic [7:0]  rows_hit;
      logic [15:0] pat;
      if (bw <= 0 || bh <= 0 || mode == plro_pkg::MODE_KEEP) return;
      r0 = (by < 0) ? 0 : by;
      r1 = (by + bh > FRAME_ROWS) ? FRAME_ROWS : by + bh;
      c0 = (bx < 0) ? 0 : bx;
      c1 = (bx + bw > FRAME_COLUMNS) ? FRAME_COLUMNS : bx + bw;
      if (r0 >= r1 || c0 >= c1) return;
      for (pg = r0 / 8; pg <= (r1 - 1) / 8; pg++) begin
         lo = ((r0 > 8 * pg) ? r0 : 8 * pg) - 8 * pg;
         hi = ((r1 < 8 * pg + 8) ? r1 : 8 * pg + 8) - 8 * pg;
         rows_hit = 8'((16'h1 << hi) - 16'h1) & ~8'((16'h1 << lo) - 16'h1);
         pat = {color[1] ? rows_hit : 8'h00, color[0] ? rows_hit : 8'h00};
         for (col = c0; col < c1; col++) begin
            idx = pg * FRAME_COLUMNS + col;
            case (mode)
               plro_pkg::MODE_PUT:   frame[idx] = frame[idx] | pat;
               plro_pkg::MODE_XOR:   frame[idx] = frame[idx] ^ pat;
               plro_pkg::MODE_ERASE: frame[idx] = frame[idx] & ~pat;
               default:              ;
            endcase
         end
      end
   endfunction

   // Apply an accepted request to the shadow frame and queue the word it returns.
   function void note_request(raster_request_type rq);
      int          x, y, w, h, lw, side, pg;
      logic [15:0] word;
      x    = int'(rq.x);
      y    = int'(rq.y);
      w    = int'(rq.cols);
      h    = int'(rq.rows);
      lw   = int'(rq.line);
      pg   = int'(rq.page);
      word = 16'h0000;
      case (rq.op)
         plro_pkg::OP_READ: begin
            if (pg < FRAME_PAGES && x < FRAME_COLUMNS) word = frame[pg * FRAME_COLUMNS + x];
         end
         plro_pkg::OP_FILL: begin
            foreach (frame[i]) frame[i] = {rq.fill, rq.fill};
         end
         plro_pkg::OP_RECT: begin
            paint_band(x, y, w, h, rq.color, rq.mode);
         end
         plro_pkg::OP_OUTLINE: begin
            if (w > 0 && h > 0 && lw > 0) begin
               side = h - 2 * lw;
               if (side < 0) side = 0;
               paint_band(x, y, w, lw, rq.color, rq.mode);
               paint_band(x, y + h - lw, w, lw, rq.color, rq.mode);
               paint_band(x, y + lw, lw, side, rq.color, rq.mode);
               paint_band(x + w - lw, y + lw, lw, side, rq.color, rq.mode);
            end
         end
         default: ;
      endcase
      planes_due.push_back(word);
   endfunction

   task check_planes(input logic [7:0] upper, input logic [7:0] lower);
      logic [15:0] want;
      responses++;
      if (planes_due.size() == 0) begin
         report_mismatch($sformatf("response %0d arrived with no request waiting", responses));
         return;
      end
      want = planes_due.pop_front();
      if (upper !== want[15:8])
         report_mismatch($sformatf("response %0d upper plane %02h, expected %02h",
                                   responses, upper, want[15:8]));
      if (lower !== want[7:0])
         report_mismatch($sformatf("response %0d lower plane %02h, expected %02h",
                                   responses, lower, want[7:0]));
   endtask
endclass

module tb_page_lcd_rect_raster_op;

   // Every input of the block starts at a known value at time zero.
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_op = '0;
   logic [6:0] req_x = '0;
   logic [7:0] req_y = '0;
   logic [7:0] req_width = '0;
   logic [7:0] req_height = '0;
   logic [6:0] req_line_width = '0;
   logic [1:0] req_color = '0;
   logic [1:0] req_mode = '0;
   logic [7:0] req_fill_byte = '0;
   logic [4:0] req_page = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_upper_plane;
   logic [7:0] rsp_lower_plane;

   // Idle and stall odds in percent. The sender's odds are read only by the stimulus
   // process itself; the receiver's odds are changed with nonblocking writes.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   // Cycles left in a long receiver hold-off. The stimulus process loads it only while it
   // is zero, and the receiver process alone counts it down.
   int hold_off_left  = 0;

   // Footprint of the most recent drawing request, so that many reads land on fresh pixels.
   int last_x = 0;
   int last_y = 0;
   int last_w = 1;
   int last_h = 1;

   frame_scoreboard_type frame_check;

   always #5 clock = ~clock;

   page_lcd_rect_raster_op #(
      .COLUMNS(FRAME_COLUMNS),
      .PAGES  (FRAME_PAGES)
   ) i_dut (.*);

   // Receiver: either sits out a hold-off, counting it down one cycle at a time, or
   // stalls at random with the odds of the current phase.
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left <= hold_off_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // Both channels are sampled at the clock edge, before any register of this edge
   // has taken its new value, so acceptance is seen exactly as the block sees it.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            frame_check.note_request(raster_request_type'({req_op, req_x, req_y, req_width,
               req_height, req_line_width, req_color, req_mode, req_fill_byte, req_page}));
         if (rsp_valid && !rsp_stall)
            frame_check.check_planes(rsp_upper_plane, rsp_lower_plane);
      end
   end

   function automatic raster_request_type make_request(plro_pkg::plro_op_type op, int x,
                                                       int y, int w, int h, int lw,
                                                       int color,
                                                       plro_pkg::plro_mode_type mode,
                                                       int fill, int page);
      raster_request_type rq;
      rq.op    = op;
      rq.x     = 7'(x);
      rq.y     = 8'(y);
      rq.cols  = 8'(w);
      rq.rows  = 8'(h);
      rq.line  = 7'(lw);
      rq.color = 2'(color);
      rq.mode  = mode;
      rq.fill  = 8'(fill);
      rq.page  = 5'(page);
      return rq;
   endfunction

   // Random request. Most shapes are small so that the run stays short; one in five
   // uses the full range of the size fields, which also exercises clipping. Fills are
   // rare because each one rewrites the whole memory.
   function automatic raster_request_type random_request();
      raster_request_type rq;
      int                 pick;
      int                 col;
      int                 row;
      logic               heavy;
      pick     = $urandom_range(0, 99);
      heavy    = ($urandom_range(0, 99) < 20);
      rq.x     = 7'($urandom_range(0, 127));
      rq.y     = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 159)) :
                                                8'($urandom_range(0, 255));
      rq.cols  = heavy ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 20));
      rq.rows  = heavy ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 32));
      rq.line  = heavy ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 8));
      rq.color = 2'($urandom_range(0, 3));
      rq.mode  = plro_pkg::plro_mode_type'($urandom_range(0, 3));
      rq.fill  = 8'($urandom_range(0, 255));
      rq.page  = 5'($urandom_range(0, 31));
      if (pick < 3) begin
         rq.op = plro_pkg::OP_FILL;
      end else if (pick < 45) begin
         rq.op = plro_pkg::OP_READ;
         if (pick < 30) begin
            // Read back a word inside the last shape drawn.
            col  = last_x + int'($urandom_range(0, last_w - 1));
            row  = last_y + int'($urandom_range(0, last_h - 1));
            rq.x = (col > 127) ? 7'(127) : 7'(col);
            rq.page = (row / 8 > 31) ? 5'(31) : 5'(row / 8);
         end else if (rq.page >= FRAME_PAGES && $urandom_range(0, 3) != 0) begin
            rq.page = 5'($urandom_range(0, FRAME_PAGES - 1));
         end
      end else begin
         rq.op  = (pick < 75) ? plro_pkg::OP_RECT : plro_pkg::OP_OUTLINE;
         last_x = int'(rq.x);
         last_y = int'(rq.y);
         last_w = (rq.cols == 0) ? 1 : int'(rq.cols);
         last_h = (rq.rows == 0) ? 1 : int'(rq.rows);
      end
      return rq;
   endfunction

   // Offers one request and returns at the edge that accepts it. Idle cycles go in
   // before the request; after acceptance valid stays high if the next call offers at once.
   task automatic offer(input raster_request_type rq);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_op, req_x, req_y, req_width, req_height, req_line_width, req_color, req_mode,
       req_fill_byte, req_page} <= rq;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic run_phase(input int count, input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct <= recv_pct;
      repeat (count) offer(random_request());
   endtask

   initial begin : stimulus
      raster_request_type directed [$];
      frame_check = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed requests, offered back to back. The block holds req_stall high during
      // its clearing pass after reset, so the first one simply waits for acceptance.
      directed = '{
         // A fresh memory reads as zero, and a page past the end reads as zero.
         make_request(plro_pkg::OP_READ,      0,   0,   0,   0,   0, 0, plro_pkg::MODE_PUT,
                      8'h00,  0),
         make_request(plro_pkg::OP_READ,    127,   0,   0,   0,   0, 0, plro_pkg::MODE_PUT,
                      8'h00, 31),
         // Fill ignores color and mode and lands in both planes.
         make_request(plro_pkg::OP_FILL,      0,   0,   0,   0,   0, 3, plro_pkg::MODE_XOR,
                      8'hA5,  0),
         make_request(plro_pkg::OP_READ,    127,   0,   0,   0,   0, 0, plro_pkg::MODE_PUT,
                      8'h00, 19),
         make_request(plro_pkg::OP_READ,      5,   0,   0,   0,   0, 0, plro_pkg::MODE_PUT,
                      8'h00, 20),
         make_request(plro_pkg::OP_FILL,      0,   0,   0,   0,   0, 0, plro_pkg::MODE_PUT,
                      8'h00,  0),
         // Full screen put, then an oversized erase of the upper plane only.
         make_request(plro_pkg::OP_RECT,      0,   0, 128, 160,   0, 3, plro_pkg::MODE_PUT,
                      8'h00,  0),
         make_request(plro_pkg::OP_READ,     64,   0,   0,   0,   0, 0, plro_pkg::MODE_PUT,
                      8'h00, 10),
         make_request(plro_pkg::OP_RECT,      0,   0, 255, 255,   0, 2, plro_pkg::MODE_ERASE,
                      8'h00,  0),
         make_request(plro_pkg::OP_READ,      0,   0,   0,   0,   0, 0, plro_pkg::MODE_PUT,
                      8'h00,  0),
         // A rectangle that starts below the last row is clipped away entirely.
         make_request(plro_pkg::OP_RECT,    127, 255, 255, 255,   0, 3, plro_pkg::MODE_XOR,
                      8'h00,  0),
         // Zero width or zero height draws nothing.
         make_request(plro_pkg::OP_RECT,      4,   4,   0,  10,   0, 3, plro_pkg::MODE_PUT,
                      8'h00,  0),
         make_request(plro_pkg::OP_RECT,      4,   4,  10,   0,   0, 3, plro_pkg::MODE_PUT,
                      8'h00,  0),
         // Rows 5 to 17 give partial masks on the first and last page of the band.
         make_request(plro_pkg::OP_RECT,      3,   5,  10,  13,   0, 1, plro_pkg::MODE_XOR,
                      8'h00,  0),
         make_request(plro_pkg::OP_READ,      5,   0,   0,   0,   0, 0, plro_pkg::MODE_PUT,
                      8'h00,  0),
         make_request(plro_pkg::OP_READ,      5,   0,   0,   0,   0, 0, plro_pkg::MODE_PUT,
                      8'h00,  2),
         // Mode three leaves the memory alone.
         make_request(plro_pkg::OP_RECT,      0,   0, 128, 160,   0, 3, plro_pkg::MODE_KEEP,
                      8'h00,  0),
         // Outline with zero line width draws nothing.
         make_request(plro_pkg::OP_OUTLINE,   0,   0,  20,  20,   0, 3, plro_pkg::MODE_PUT,
                      8'h00,  0),
         // Line width far beyond the size: the bottom band and the right band start at
         // negative positions and the side bands have zero height.
         make_request(plro_pkg::OP_OUTLINE,   0,   0,   5,  10,  80, 3, plro_pkg::MODE_XOR,
                      8'h00,  0),
         make_request(plro_pkg::OP_READ,      0,   0,   0,   0,   0, 0, plro_pkg::MODE_PUT,
                      8'h00,  0),
         // Outline hanging over the right and bottom edges.
         make_request(plro_pkg::OP_OUTLINE, 100, 150,  40,  20,   3, 2, plro_pkg::MODE_PUT,
                      8'h00,  0),
         make_request(plro_pkg::OP_READ,    127,   0,   0,   0,   0, 0, plro_pkg::MODE_PUT,
                      8'h00, 19),
         make_request(plro_pkg::OP_OUTLINE,  10,  20,  30,  30, 127, 1, plro_pkg::MODE_ERASE,
                      8'h00,  0),
         // Ordinary outline in xor mode, where the bands share display words at the corners.
         make_request(plro_pkg::OP_OUTLINE,  40,   8,  24,  24,   4, 3, plro_pkg::MODE_XOR,
                      8'h00,  0),
         make_request(plro_pkg::OP_READ,     40,   0,   0,   0,   0, 0, plro_pkg::MODE_PUT,
                      8'h00,  1)
      };
      foreach (directed[i]) offer(directed[i]);

      // Random traffic under each idling pattern in turn.
      run_phase(40,  0,  0);
      run_phase(40, 76,  0);
      run_phase(40,  0, 76);
      run_phase(40, 24, 24);

      // Long receiver hold-off while the sender keeps offering: one request finishes
      // into the response register, the next is taken in, and then req_stall must rise.
      send_idle_pct = 0;
      recv_stall_pct <= 0;
      hold_off_left <= 400;
      repeat (20) offer(random_request());

      run_phase(25, 0, 0);
      req_valid <= 1'b0;

      // Every request gives one response; once all are in, keep waiting so that anything
      // stray can still show up.
      while (frame_check.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (frame_check.mismatches == 0 && frame_check.pending() == 0) begin
         $display("tb_page_lcd_rect_raster_op passed");
      end else begin
         $display("tb_page_lcd_rect_raster_op failed");
      end
      $finish;
   end

   // Safety net: far beyond a run made only of the largest outlines under the heaviest
   // stalling.
   initial begin : watchdog
      #100_000_000;
      $display("tb_page_lcd_rect_raster_op failed");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/plro_pkg.sv
rtl/plro_ram.sv
rtl/plro_walker.sv
rtl/page_lcd_rect_raster_op.sv
rtl/plro_checker.sv
tb/sv/tb_page_lcd_rect_raster_op.sv
